>>> hdl/knps_pkg.sv
// Package: shared constants of the k-nearest point selector.
`default_nettype none
package knps_pkg;
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam logic CFG_LIGHTS_IN_USE = 1'b0;
    localparam logic CFG_NEAREST_COUNT = 1'b1;
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam int unsigned LIU_BITS = 7;
    localparam int unsigned NC_BITS = 4;
    localparam int unsigned CFG_DATA_BITS = 7;
    localparam int unsigned RANK_BITS = 3;
    localparam int unsigned DIST_BITS = 50;
    localparam logic [NC_BITS-1:0] NC_RESET = 4'd8;
endpackage
`default_nettype wire

>>> hdl/knps_if.sv
// Interfaces: valid/ready item channel and configuration write channel.
`default_nettype none
interface knps_stream_if #(
    parameter int unsigned WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface knps_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [knps_pkg::CFG_IDX_BITS-1:0]       index;
    logic [knps_pkg::CFG_DATA_BITS-1:0]      wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

>>> hdl/k_nearest_point_selector.sv
// Top level: k-nearest point selector with configuration registers.
// A query reads the table once, one entry per cycle
// through a three-stage distance pipeline into an eight-deep sorted insertion list.
// A two-item queue sits in front of the datapath, and one item is processed at a time.
`default_nettype none
module k_nearest_point_selector #(
    parameter int unsigned NUM_LIGHTS  = 64,
    parameter int unsigned MAX_NEAREST = 8,
    parameter int unsigned COORD_BITS  = 24
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    knps_stream_if.sink  i_in,
    knps_stream_if.source o_out,
    knps_cfg_if.sink     i_cfg
);
    localparam int unsigned IDX_BITS = 6;
    localparam int unsigned IW = 1 + IDX_BITS + 3 * COORD_BITS;

    logic [knps_pkg::LIU_BITS-1:0] r_lights_in_use;
    logic [knps_pkg::NC_BITS-1:0]  r_nearest_count;
    logic          q_valid, q_ready;
    logic [IW-1:0] q_data;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lights_in_use <= '0;
            r_nearest_count <= knps_pkg::NC_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                knps_pkg::CFG_LIGHTS_IN_USE: r_lights_in_use <= i_cfg.wdata;
                knps_pkg::CFG_NEAREST_COUNT:
                    r_nearest_count <= i_cfg.wdata[knps_pkg::NC_BITS-1:0];
                default: ;
            endcase
        end
    end

    knps_front #(.W(IW)) u_front (
        .i_clk, .i_rst_n, .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_data(i_in.data), .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data));

    knps_back #(.NUM_LIGHTS(NUM_LIGHTS), .MAX_NEAREST(MAX_NEAREST),
                .COORD_BITS(COORD_BITS), .IDX_BITS(IDX_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready),
        .i_cmd(q_data[IW-1]),
        .i_light_index(q_data[IW-2 -: IDX_BITS]),
        .i_coord_x(q_data[3*COORD_BITS-1 -: COORD_BITS]),
        .i_coord_y(q_data[2*COORD_BITS-1 -: COORD_BITS]),
        .i_coord_z(q_data[COORD_BITS-1:0]),
        .i_lights_in_use(r_lights_in_use), .i_nearest_count(r_nearest_count),
        .o_valid(o_out.valid), .i_ready(o_out.ready),
        .o_nearest_index(o_out.data[60:55]),
        .o_distance_squared(o_out.data[54:5]),
        .o_rank(o_out.data[4:2]), .o_found(o_out.data[1]), .o_last(o_out.data[0]));
endmodule
`default_nettype wire

>>> hdl/knps_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module knps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hdl/knps_front.sv
// Front end: accepts items and queues them in a two-entry FIFO for the back end.
`default_nettype none
module knps_front #(
    parameter int unsigned W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic      [W-1:0] o_data
);
    logic [W-1:0] r_q [2];
    logic         r_rd;
    logic         r_wr;
    logic [1:0]   r_cnt;
    logic         push;
    logic         pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |=> (r_cnt <= 2'd1))
        else $error("queue jumped from empty");
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_ready) |=> (r_cnt == 2'd2))
        else $error("full queue changed without pop");
endmodule
`default_nettype wire

>>> hdl/knps_back.sv
// Back end: stores points, scans the table and emits the nearest entries in order.
`default_nettype none
module knps_back #(
    parameter int unsigned NUM_LIGHTS  = 64,
    parameter int unsigned MAX_NEAREST = 8,
    parameter int unsigned COORD_BITS  = 24,
    parameter int unsigned IDX_BITS    = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_cmd,
    input  wire logic [IDX_BITS-1:0]           i_light_index,
    input  wire logic signed [COORD_BITS-1:0]  i_coord_x,
    input  wire logic signed [COORD_BITS-1:0]  i_coord_y,
    input  wire logic signed [COORD_BITS-1:0]  i_coord_z,
    input  wire logic [knps_pkg::LIU_BITS-1:0] i_lights_in_use,
    input  wire logic [knps_pkg::NC_BITS-1:0]  i_nearest_count,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [IDX_BITS-1:0]                o_nearest_index,
    output logic [knps_pkg::DIST_BITS-1:0]     o_distance_squared,
    output logic [knps_pkg::RANK_BITS-1:0]     o_rank,
    output logic                               o_found,
    output logic                               o_last
);
    localparam int unsigned AW = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
    localparam int unsigned CW = $clog2(NUM_LIGHTS + 1);
    localparam int unsigned KW = $clog2(MAX_NEAREST + 1);
    localparam int unsigned NW = (MAX_NEAREST > 1) ? $clog2(MAX_NEAREST) : 1;
    localparam int unsigned DW = 2 * COORD_BITS + 2;
    localparam int unsigned SW = COORD_BITS + 1;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_OUT} t_state;

    t_state               r_state;
    logic [CW-1:0]        r_used;
    logic [KW-1:0]        r_want;
    logic [CW-1:0]        r_issue;
    logic [KW-1:0]        r_fill;
    logic [KW-1:0]        r_emit;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic [DW-1:0]        r_dist [MAX_NEAREST];
    logic [AW-1:0]        r_idx  [MAX_NEAREST];
    // distance pipeline
    logic                 r_rdv;
    logic [AW-1:0]        r_ra;
    logic                 r_v1, r_v2, r_v3;
    logic [AW-1:0]        r_i1, r_i2, r_i3;
    logic [SW-1:0]        r_ax, r_ay, r_az;
    logic [2*SW-1:0]      r_sx, r_sy, r_sz;
    logic [DW-1:0]        r_d3;
    logic [COORD_BITS-1:0] ram_x, ram_y, ram_z;
    logic                 we;
    logic [AW-1:0]        raddr;
    logic [CW-1:0]        used_sat;
    logic [KW-1:0]        want_c;
    logic signed [SW-1:0] dx, dy, dz;
    logic [MAX_NEAREST-1:0] closer;

    assign we    = (r_state == S_IDLE) && i_valid && (i_cmd == knps_pkg::CMD_STORE)
                   && ({{(32-IDX_BITS){1'b0}}, i_light_index} < NUM_LIGHTS);
    assign raddr = r_issue[AW-1:0];
    assign o_ready = (r_state == S_IDLE);

    knps_ram #(.WIDTH(COORD_BITS), .DEPTH(NUM_LIGHTS)) u_ram_x (
        .i_clk, .i_we(we), .i_waddr(AW'(i_light_index)), .i_wdata(i_coord_x),
        .i_raddr(raddr), .o_rdata(ram_x));
    knps_ram #(.WIDTH(COORD_BITS), .DEPTH(NUM_LIGHTS)) u_ram_y (
        .i_clk, .i_we(we), .i_waddr(AW'(i_light_index)), .i_wdata(i_coord_y),
        .i_raddr(raddr), .o_rdata(ram_y));
    knps_ram #(.WIDTH(COORD_BITS), .DEPTH(NUM_LIGHTS)) u_ram_z (
        .i_clk, .i_we(we), .i_waddr(AW'(i_light_index)), .i_wdata(i_coord_z),
        .i_raddr(raddr), .o_rdata(ram_z));

    always_comb begin
        if ({{(32-knps_pkg::LIU_BITS){1'b0}}, i_lights_in_use} > NUM_LIGHTS) begin
            used_sat = CW'(NUM_LIGHTS);
        end else begin
            used_sat = CW'(i_lights_in_use);
        end
        if (i_nearest_count == '0) begin
            want_c = KW'(1);
        end else if ({{(32-knps_pkg::NC_BITS){1'b0}}, i_nearest_count} > MAX_NEAREST) begin
            want_c = KW'(MAX_NEAREST);
        end else begin
            want_c = KW'(i_nearest_count);
        end
        if (32'(want_c) > 32'(used_sat)) begin
            want_c = KW'(used_sat);
        end
        dx = SW'(r_px) - SW'($signed(ram_x));
        dy = SW'(r_py) - SW'($signed(ram_y));
        dz = SW'(r_pz) - SW'($signed(ram_z));
        for (int k = 0; k < MAX_NEAREST; k++) begin
            closer[k] = (32'(k) >= 32'(r_fill)) || (r_d3 < r_dist[k]);
        end
    end

    // distance pipeline: read, abs, square, sum
    always_ff @(posedge i_clk) begin
        r_ra <= raddr;
        r_ax <= dx[SW-1] ? SW'(-dx) : SW'(dx);
        r_ay <= dy[SW-1] ? SW'(-dy) : SW'(dy);
        r_az <= dz[SW-1] ? SW'(-dz) : SW'(dz);
        r_i1 <= r_ra;
        r_sx <= r_ax * r_ax;
        r_sy <= r_ay * r_ay;
        r_sz <= r_az * r_az;
        r_i2 <= r_i1;
        r_d3 <= DW'(r_sx) + DW'(r_sy) + DW'(r_sz);
        r_i3 <= r_i2;
        if (!i_rst_n) begin
            r_rdv <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_rdv <= (r_state == S_SCAN);
            r_v1 <= r_rdv;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_fill  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid && i_cmd == knps_pkg::CMD_QUERY) begin
                        r_px <= i_coord_x;
                        r_py <= i_coord_y;
                        r_pz <= i_coord_z;
                        r_used <= used_sat;
                        r_want <= want_c;
                        r_issue <= '0;
                        r_fill <= '0;
                        r_emit <= '0;
                        r_state <= (used_sat == '0) ? S_OUT : S_SCAN;
                        if (used_sat == '0) begin
                            o_valid <= 1'b1;
                            o_found <= 1'b0;
                            o_last <= 1'b1;
                            o_rank <= '0;
                            o_nearest_index <= '0;
                            o_distance_squared <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    // read issued at r_issue; data valid next cycle
                    if (r_issue + 1'b1 < r_used) r_issue <= r_issue + 1'b1;
                    else r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (!r_rdv && !r_v1 && !r_v2 && !r_v3) begin
                        r_state <= S_OUT;
                        o_valid <= 1'b1;
                        o_found <= 1'b1;
                        o_rank <= '0;
                        o_nearest_index <= IDX_BITS'(r_idx[0]);
                        o_distance_squared <= knps_pkg::DIST_BITS'(r_dist[0]);
                        o_last <= (r_want == KW'(1));
                        r_emit <= KW'(1);
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (o_last) begin
                            o_valid <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            o_rank <= knps_pkg::RANK_BITS'(r_emit);
                            o_nearest_index <= IDX_BITS'(r_idx[r_emit[NW-1:0]]);
                            o_distance_squared <= knps_pkg::DIST_BITS'(
                                r_dist[r_emit[NW-1:0]]);
                            o_last <= (r_emit + 1'b1 == r_want);
                            r_emit <= r_emit + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_v3 && r_fill < KW'(MAX_NEAREST)) r_fill <= r_fill + 1'b1;
        end
    end

    // sorted insertion list; strict compare keeps earlier (lower) index first on ties
    always_ff @(posedge i_clk) begin
        if (r_v3) begin
            for (int k = 0; k < MAX_NEAREST; k++) begin
                if (closer[k]) begin
                    if (k == 0 || !closer[(k == 0) ? 0 : k-1]) begin
                        r_dist[k] <= r_d3;
                        r_idx[k]  <= r_i3;
                    end else begin
                        r_dist[k] <= r_dist[(k == 0) ? 0 : k-1];
                        r_idx[k]  <= r_idx[(k == 0) ? 0 : k-1];
                    end
                end
            end
        end
    end

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT))
        else $error("result shown outside output phase");
    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (32'(o_rank) < 32'(r_want)))
        else $error("rank beyond requested count");
    a_nf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> o_last)
        else $error("not-found result not last");
endmodule
`default_nettype wire

>>> dv/k_nearest_point_selector_test.sv
// Testbench: k-nearest point selector checked item by item against a behavioral predictor.
`default_nettype none
module k_nearest_point_selector_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              cmd;
        logic [5:0]        light_index;
        logic signed [23:0] coord_x;
        logic signed [23:0] coord_y;
        logic signed [23:0] coord_z;
    } t_point_item;

    typedef struct packed {
        logic [5:0]                     nearest_index;
        logic [knps_pkg::DIST_BITS-1:0] distance_squared;
        logic [knps_pkg::RANK_BITS-1:0] rank;
        logic                           found;
        logic                           last;
    } t_nearest;

    typedef enum int {ROW_ITEM, ROW_ITEM_TYPED, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_point_item item;
        t_nearest    typed;
        logic        cfg_index;
        int unsigned cfg_value;
    } t_row;

    localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [23:0] CMIN = -24'sh800000;
    localparam longint unsigned SPAN_SQ = 64'd16777215 * 64'd16777215;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   idle_mode;

    knps_stream_if #(.WIDTH($bits(t_point_item))) in_if ();
    knps_stream_if #(.WIDTH($bits(t_nearest)))    out_if ();
    knps_cfg_if                                   cfg_if ();

    k_nearest_point_selector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    logic signed [23:0] pos_x [64];
    logic signed [23:0] pos_y [64];
    logic signed [23:0] pos_z [64];
    int unsigned lights_reg;
    int unsigned count_reg;
    t_nearest    nearest_q [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic predict_nearest(input t_point_item it);
        longint unsigned dsq [64];
        bit              taken [64];
        longint signed   d;
        int unsigned     used;
        int unsigned     want;
        int              best;
        t_nearest        r;
        if (it.cmd == knps_pkg::CMD_STORE) begin
            pos_x[it.light_index] = it.coord_x;
            pos_y[it.light_index] = it.coord_y;
            pos_z[it.light_index] = it.coord_z;
            return;
        end
        used = (lights_reg > 64) ? 64 : lights_reg;
        if (used == 0) begin
            r = '0;
            r.last = 1'b1;
            nearest_q = {nearest_q, r};
            return;
        end
        want = (count_reg == 0) ? 1 : (count_reg > 8 ? 8 : count_reg);
        if (want > used) want = used;
        for (int i = 0; i < used; i++) begin
            dsq[i] = 0;
            d = longint'(it.coord_x) - longint'(pos_x[i]);
            dsq[i] += d * d;
            d = longint'(it.coord_y) - longint'(pos_y[i]);
            dsq[i] += d * d;
            d = longint'(it.coord_z) - longint'(pos_z[i]);
            dsq[i] += d * d;
            taken[i] = 1'b0;
        end
        for (int k = 0; k < want; k++) begin
            best = -1;
            for (int i = 0; i < used; i++)
                if (!taken[i] && (best < 0 || dsq[i] < dsq[best])) best = i;
            taken[best] = 1'b1;
            r.nearest_index    = best[5:0];
            r.distance_squared = dsq[best][knps_pkg::DIST_BITS-1:0];
            r.rank             = k[knps_pkg::RANK_BITS-1:0];
            r.found            = 1'b1;
            r.last             = (k + 1 == want);
            nearest_q = {nearest_q, r};
        end
    endtask

    task automatic send_item(input t_point_item it, input bit typed, input t_nearest exp_r);
        int unsigned idle_pct;
        idle_pct = (idle_mode == 3) ? 31 : 77;
        if (idle_mode == 1 || idle_mode == 3) begin
            while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.data  = it;
        forever begin
            @(posedge i_clk);
            if (in_if.ready) break;
        end
        if (typed) nearest_q = {nearest_q, exp_r};
        else predict_nearest(it);
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    task automatic drain();
        while (nearest_q.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned value);
        drain();
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.wdata = value[knps_pkg::CFG_DATA_BITS-1:0];
        forever begin
            @(posedge i_clk);
            if (cfg_if.ready) break;
        end
        if (idx == knps_pkg::CFG_LIGHTS_IN_USE) lights_reg = value & 32'h7F;
        else count_reg = value & 32'hF;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic signed [23:0] rand_coord();
        int unsigned sel;
        sel = $urandom_range(3);
        case (sel)
            0: return 24'($urandom);
            1: begin
                case ($urandom_range(4))
                    0: return CMAX;
                    1: return CMIN;
                    2: return 24'sd1;
                    3: return -24'sd1;
                    default: return 24'sd0;
                endcase
            end
            default: return $signed(24'($urandom_range(8))) - 24'sd4;
        endcase
    endfunction

    function automatic t_point_item mk(input logic cmd, input int idx,
                                       input logic signed [23:0] x,
                                       input logic signed [23:0] y,
                                       input logic signed [23:0] z);
        t_point_item it;
        it.cmd = cmd;
        it.light_index = idx[5:0];
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        return it;
    endfunction

    always @(negedge i_clk) begin
        if (idle_mode == 2) out_if.ready <= ($urandom_range(99) >= 77);
        else if (idle_mode == 3) out_if.ready <= ($urandom_range(99) >= 31);
        else out_if.ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_nearest got;
        t_nearest want_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (nearest_q.size() == 0) begin
                report("result with nothing expected");
            end else begin
                want_r = nearest_q.pop_front();
                if (got.nearest_index !== want_r.nearest_index)
                    report($sformatf("index %0d exp %0d", got.nearest_index,
                                     want_r.nearest_index));
                if (got.distance_squared !== want_r.distance_squared)
                    report($sformatf("dist %0d exp %0d", got.distance_squared,
                                     want_r.distance_squared));
                if (got.rank !== want_r.rank)
                    report($sformatf("rank %0d exp %0d", got.rank, want_r.rank));
                if (got.found !== want_r.found)
                    report($sformatf("found %0b exp %0b", got.found, want_r.found));
                if (got.last !== want_r.last)
                    report($sformatf("last %0b exp %0b", got.last, want_r.last));
            end
        end
    end

    initial begin
        t_row        rows [$];
        t_row        rw;
        t_nearest    none_r;
        t_nearest    far_r;
        int unsigned liu_set [4];
        int unsigned nc_set [4];
        int          waited;

        errors = 0;
        idle_mode = 0;
        lights_reg = 0;
        count_reg = knps_pkg::NC_RESET;
        in_if.valid = 1'b0;
        in_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = knps_pkg::CFG_LIGHTS_IN_USE;
        cfg_if.wdata = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        none_r = '0;
        none_r.last = 1'b1;
        far_r.nearest_index = 6'd0;
        far_r.distance_squared = knps_pkg::DIST_BITS'(3 * SPAN_SQ);
        far_r.rank = '0;
        far_r.found = 1'b1;
        far_r.last = 1'b1;

        // empty table, then extremes, ties and saturated registers
        rw = '{ROW_ITEM_TYPED, mk(knps_pkg::CMD_QUERY, 63, CMAX, CMIN, 0), none_r, 0, 0};
        rows = {rows, rw};
        rw = '{ROW_ITEM, mk(knps_pkg::CMD_STORE, 0, CMAX, CMAX, CMAX), none_r, 0, 0};
        rows = {rows, rw};
        rw = '{ROW_ITEM, mk(knps_pkg::CMD_STORE, 63, CMIN, CMIN, CMIN), none_r, 0, 0};
        rows = {rows, rw};
        rw = '{ROW_CFG, '0, none_r, knps_pkg::CFG_LIGHTS_IN_USE, 1};
        rows = {rows, rw};
        rw = '{ROW_CFG, '0, none_r, knps_pkg::CFG_NEAREST_COUNT, 0};
        rows = {rows, rw};
        rw = '{ROW_ITEM_TYPED, mk(knps_pkg::CMD_QUERY, 0, CMIN, CMIN, CMIN), far_r, 0, 0};
        rows = {rows, rw};
        rw = '{ROW_ITEM, mk(knps_pkg::CMD_STORE, 1, 0, 0, 0), none_r, 0, 0};
        rows = {rows, rw};
        rw = '{ROW_ITEM, mk(knps_pkg::CMD_STORE, 2, 0, 0, 0), none_r, 0, 0};
        rows = {rows, rw};
        rw = '{ROW_ITEM, mk(knps_pkg::CMD_STORE, 3, 1, -1, 1), none_r, 0, 0};
        rows = {rows, rw};
        rw = '{ROW_CFG, '0, none_r, knps_pkg::CFG_LIGHTS_IN_USE, 4};
        rows = {rows, rw};
        rw = '{ROW_CFG, '0, none_r, knps_pkg::CFG_NEAREST_COUNT, 15};
        rows = {rows, rw};
        rw = '{ROW_ITEM, mk(knps_pkg::CMD_QUERY, 5, 0, 0, 0), none_r, 0, 0};
        rows = {rows, rw};
        rw = '{ROW_ITEM, mk(knps_pkg::CMD_QUERY, 0, CMAX, CMAX, CMAX), none_r, 0, 0};
        rows = {rows, rw};
        rw = '{ROW_CFG, '0, none_r, knps_pkg::CFG_NEAREST_COUNT, 2};
        rows = {rows, rw};
        rw = '{ROW_ITEM, mk(knps_pkg::CMD_QUERY, 0, 1, 0, 1), none_r, 0, 0};
        rows = {rows, rw};
        rw = '{ROW_ITEM, mk(knps_pkg::CMD_QUERY, 0, CMIN, CMAX, 0), none_r, 0, 0};
        rows = {rows, rw};

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].cfg_index, rows[i].cfg_value);
            else
                send_item(rows[i].item, rows[i].kind == ROW_ITEM_TYPED, rows[i].typed);
        end

        // fill the whole table so any lights_in_use setting reads written entries
        for (int i = 0; i < 64; i++)
            send_item(mk(knps_pkg::CMD_STORE, i, rand_coord(), rand_coord(), rand_coord()),
                      0, none_r);

        liu_set = '{64, 127, 1, 37};
        nc_set  = '{8, 1, 5, 3};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(knps_pkg::CFG_LIGHTS_IN_USE, liu_set[ph]);
            write_reg(knps_pkg::CFG_NEAREST_COUNT, nc_set[ph]);
            idle_mode = ph;
            for (int n = 0; n < 72; n++) begin
                if (ph == 1 && n == 36) begin
                    while (nearest_q.size() != 0) @(negedge i_clk);
                end
                if ($urandom_range(99) < 60)
                    send_item(mk(knps_pkg::CMD_QUERY, $urandom_range(63), rand_coord(),
                                 rand_coord(), rand_coord()), 0, none_r);
                else
                    send_item(mk(knps_pkg::CMD_STORE, $urandom_range(63), rand_coord(),
                                 rand_coord(), rand_coord()), 0, none_r);
            end
        end

        waited = 0;
        while (nearest_q.size() != 0 && waited < 200000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (100) @(negedge i_clk);
        if (nearest_q.size() != 0) report("results still expected at end");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
